// ===== rtl/plrb_pkg.sv =====
// Shared types, constants and helpers for the ping-pong line receive buffer.
// Depends on nothing; every other file imports it.
package plrb_pkg;

    // Bytes per line buffer and derived widths
    localparam int LINE_BYTES = 128;
    localparam int OFF_W      = $clog2(LINE_BYTES);      // offset inside one buffer
    localparam int LEN_W      = $clog2(LINE_BYTES + 1);  // count 0..LINE_BYTES
    localparam int ADDR_W     = OFF_W + 1;               // buffer select + offset
    localparam int DEPTH      = 2 * LINE_BYTES;

    // Fixed field widths of the stream items
    localparam int KIND_W      = 2;
    localparam int BYTE_W      = 8;
    localparam int RD_OFF_W    = 7;
    localparam int LENGTH_W    = 8;
    localparam int S_TDATA_W   = 16;
    localparam int M_TDATA_W   = 24;

    // Item kinds
    localparam logic [KIND_W-1:0] KIND_BYTE    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_GET     = 2'd1;
    localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd2;
    localparam logic [KIND_W-1:0] KIND_READ    = 2'd3;

    // Checked-out code meaning no buffer
    localparam logic [1:0] NO_BUFFER = 2'd3;

    // Line terminator characters
    localparam logic [BYTE_W-1:0] CHAR_CR = 8'h0D;
    localparam logic [BYTE_W-1:0] CHAR_LF = 8'h0A;

    // Line store access for one item
    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [BYTE_W-1:0] wr_data;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
    } mem_req_t;

    // Result fields except the byte that comes from the store
    typedef struct packed {
        logic                buffer_ready;
        logic                checkout_sel;
        logic [LENGTH_W-1:0] line_length;
        logic                line_done;
        logic                byte_dropped;
        logic                data_available;
        logic                capture_paused;
        logic                read_hit;
    } result_t;

    // Free buffer search, buffer 0 first
    typedef struct packed {
        logic found;
        logic idx;
    } pick_t;

    function automatic pick_t pick_free(input logic len0_zero, input logic len1_zero,
                                        input logic [1:0] co);
        pick_t p;
        p.found = 1'b0;
        p.idx   = 1'b0;
        if (len0_zero && co != 2'd0)
        begin
            p.found = 1'b1;
            p.idx   = 1'b0;
        end
        else if (len1_zero && co != 2'd1)
        begin
            p.found = 1'b1;
            p.idx   = 1'b1;
        end
        return p;
    endfunction

endpackage

// ===== rtl/plrb_store.sv =====
// Line store: two line buffers in one single-port-write, registered-read memory.
// Depends on plrb_pkg.
module plrb_store
    import plrb_pkg::*;
(
    input  logic              clk,
    input  mem_req_t          req,
    output logic [BYTE_W-1:0] rd_data
);

    logic [BYTE_W-1:0] mem [DEPTH];
    logic [BYTE_W-1:0] rd_data_reg;

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/plrb_ctrl.sv =====
// Capture and host-side control: fill position, published lengths, checkout.
// Depends on plrb_pkg; drives the line store request and the result fields.
module plrb_ctrl
    import plrb_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                fire,
    input  logic [KIND_W-1:0]   kind,
    input  logic [BYTE_W-1:0]   rx_byte,
    input  logic [RD_OFF_W-1:0] read_offset,
    output mem_req_t            mem_req,
    output result_t             result
);

    logic [LEN_W-1:0]  len_reg [2];
    logic [LEN_W-1:0]  len_next [2];
    logic              fill_buf_reg, fill_buf_next;
    logic              capturing_reg, capturing_next;
    logic              paused_reg, paused_next;
    logic [LEN_W-1:0]  fill_cnt_reg, fill_cnt_next;
    logic [BYTE_W-1:0] prev_byte_reg, prev_byte_next;
    logic              prev_valid_reg, prev_valid_next;
    logic [1:0]        co_reg, co_next;

    logic [LEN_W-1:0]  cnt_inc;
    logic              pair_end;
    logic              complete;
    logic              restart;
    logic              done;
    logic              dropped;
    logic              rd_len_ok;
    pick_t             pick;

    assign cnt_inc  = fill_cnt_reg + 1'b1;
    assign pair_end = prev_valid_reg &&
                      ((prev_byte_reg == CHAR_CR && rx_byte == CHAR_LF) ||
                       (prev_byte_reg == CHAR_LF && rx_byte == CHAR_CR));
    assign complete = pair_end || (cnt_inc == LEN_W'(LINE_BYTES));
    assign rd_len_ok = (32'(read_offset) < 32'(len_reg[co_reg[0]])) &&
                       (32'(read_offset) < LINE_BYTES);

    // Next state for the item in flight
    always_comb
    begin
        len_next        = len_reg;
        fill_buf_next   = fill_buf_reg;
        capturing_next  = capturing_reg;
        paused_next     = paused_reg;
        fill_cnt_next   = fill_cnt_reg;
        prev_byte_next  = prev_byte_reg;
        prev_valid_next = prev_valid_reg;
        co_next         = co_reg;
        restart         = 1'b0;
        done            = 1'b0;
        dropped         = 1'b0;
        mem_req.wr_en   = 1'b0;
        mem_req.wr_addr = {fill_buf_reg, fill_cnt_reg[OFF_W-1:0]};
        mem_req.wr_data = rx_byte;
        mem_req.rd_en   = 1'b0;
        mem_req.rd_addr = {co_reg[0], OFF_W'(read_offset)};

        if (fire)
        begin
            unique case (kind)
                KIND_BYTE:
                begin
                    if (!capturing_reg)
                    begin
                        dropped = 1'b1;
                    end
                    else
                    begin
                        mem_req.wr_en = 1'b1;
                        fill_cnt_next = cnt_inc;
                        if (!complete)
                        begin
                            prev_byte_next  = rx_byte;
                            prev_valid_next = 1'b1;
                        end
                        else
                        begin
                            capturing_next         = 1'b0;
                            len_next[fill_buf_reg] = cnt_inc;
                            done                   = 1'b1;
                            restart                = 1'b1;
                        end
                    end
                end
                KIND_GET:
                begin
                    if (co_reg == NO_BUFFER)
                    begin
                        if (len_reg[0] != '0)
                        begin
                            co_next = 2'd0;
                        end
                        else if (len_reg[1] != '0)
                        begin
                            co_next = 2'd1;
                        end
                    end
                end
                KIND_RELEASE:
                begin
                    if (co_reg != NO_BUFFER)
                    begin
                        len_next[co_reg[0]] = '0;
                        co_next             = NO_BUFFER;
                    end
                    restart = paused_reg && !capturing_reg;
                end
                KIND_READ:
                begin
                    mem_req.rd_en = 1'b1;
                end
            endcase
        end

        // Move capture to a free buffer, or pause
        pick = pick_free(len_next[0] == '0, len_next[1] == '0, co_next);
        if (restart)
        begin
            if (pick.found)
            begin
                fill_buf_next   = pick.idx;
                fill_cnt_next   = '0;
                prev_valid_next = 1'b0;
                capturing_next  = 1'b1;
                paused_next     = 1'b0;
            end
            else
            begin
                paused_next = 1'b1;
            end
        end
    end

    // Result fields from the updated state
    always_comb
    begin
        result.buffer_ready   = (co_next != NO_BUFFER);
        result.checkout_sel   = (co_next != NO_BUFFER) ? co_next[0] : 1'b0;
        result.line_length    = (co_next != NO_BUFFER) ?
                                LENGTH_W'(len_next[co_next[0]]) : '0;
        result.line_done      = done;
        result.byte_dropped   = dropped;
        result.data_available = (co_next != NO_BUFFER) || (len_next[0] != '0) ||
                                (len_next[1] != '0);
        result.capture_paused = paused_next;
        result.read_hit       = fire && (kind == KIND_READ) && (co_reg != NO_BUFFER) &&
                                rd_len_ok;
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg[0]     <= '0;
            len_reg[1]     <= '0;
            fill_buf_reg   <= 1'b0;
            capturing_reg  <= 1'b1;
            paused_reg     <= 1'b0;
            fill_cnt_reg   <= '0;
            prev_byte_reg  <= '0;
            prev_valid_reg <= 1'b0;
            co_reg         <= NO_BUFFER;
        end
        else
        begin
            len_reg[0]     <= len_next[0];
            len_reg[1]     <= len_next[1];
            fill_buf_reg   <= fill_buf_next;
            capturing_reg  <= capturing_next;
            paused_reg     <= paused_next;
            fill_cnt_reg   <= fill_cnt_next;
            prev_byte_reg  <= prev_byte_next;
            prev_valid_reg <= prev_valid_next;
            co_reg         <= co_next;
        end
    end

endmodule

// ===== rtl/pingpong_line_receive_buffer.sv =====
// Top level of the ping-pong line receive buffer: input register, control, store,
// result register. Depends on plrb_pkg, plrb_ctrl and plrb_store.
//
//  channel | direction | fields (low bit first)
//  --------+-----------+-----------------------------------------------------------
//  s_*     | in        | tuser: kind[1:0]; tdata: rx_byte[7:0], read_offset[14:8]
//  m_*     | out       | tdata: buffer_ready, checkout_sel, line_length[9:2],
//          |           |        read_data[17:10], line_done, byte_dropped,
//          |           |        data_available, capture_paused
//
// One item per cycle sustained while the result is not stalled; each item passes the input
// register, then the control update and store read into the result register.
// The store is written and read once per cycle at most, which sets the rate.
// Reset leaves capture armed on buffer 0; the store needs no clearing pass.
// A stalled result holds; s_tready stays high while the result register can drain.
module pingpong_line_receive_buffer
    import plrb_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // rx_byte[7:0], read_offset[14:8], pad
    input  logic [KIND_W-1:0]    s_tuser,   // kind[1:0]
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata    // see table above, pad [23:22]
);

    logic                in_valid_reg;
    logic [KIND_W-1:0]   in_kind_reg;
    logic [BYTE_W-1:0]   in_byte_reg;
    logic [RD_OFF_W-1:0] in_off_reg;
    logic                out_valid_reg;
    result_t             out_res_reg;
    logic                advance;
    logic                fire;
    mem_req_t            mem_req;
    result_t             result;
    logic [BYTE_W-1:0]   rd_data;
    logic [BYTE_W-1:0]   read_data;

    // Pipeline handshake
    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;
    assign fire     = in_valid_reg && advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_kind_reg <= s_tuser;
            in_byte_reg <= s_tdata[BYTE_W-1:0];
            in_off_reg  <= s_tdata[BYTE_W+RD_OFF_W-1:BYTE_W];
        end
        if (fire)
        begin
            out_res_reg <= result;
        end
    end

    plrb_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .fire        (fire),
        .kind        (in_kind_reg),
        .rx_byte     (in_byte_reg),
        .read_offset (in_off_reg),
        .mem_req     (mem_req),
        .result      (result)
    );

    plrb_store u_store (
        .clk     (clk),
        .req     (mem_req),
        .rd_data (rd_data)
    );

    // Result packing
    assign read_data = out_res_reg.read_hit ? rd_data : '0;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {2'b00,
                        out_res_reg.capture_paused,
                        out_res_reg.data_available,
                        out_res_reg.byte_dropped,
                        out_res_reg.line_done,
                        read_data,
                        out_res_reg.line_length,
                        out_res_reg.checkout_sel,
                        out_res_reg.buffer_ready};

endmodule

// ===== rtl/plrb_checker.sv =====
// Port-level checks for the ping-pong line receive buffer, bound to the top level.
// Depends on plrb_pkg.
module plrb_checker
    import plrb_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    // A dropped byte never completes a line
    a_drop_not_done: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tdata[18] && m_tdata[19]))
        else $error("dropped byte also reported a finished line");

    // No checkout means zero index and zero length
    a_idle_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tdata[0]) |-> (m_tdata[1] == 1'b0 && m_tdata[9:2] == '0))
        else $error("index or length nonzero with nothing checked out");

    // A checked-out buffer always counts as available data, with a legal length
    a_ready_avail: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[0]) |->
            (m_tdata[20] && 32'(m_tdata[9:2]) <= LINE_BYTES))
        else $error("checked-out buffer without data available or length too big");

    // A stalled result holds
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("result changed while stalled");

endmodule

bind pingpong_line_receive_buffer plrb_checker u_plrb_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
